/* hw/rtl/lpa_pkg.sv */
// ----------------------------------------------------------------------------
// lpa_pkg
// Shared types, codes and defaults for the LIFO pool allocator.
// ----------------------------------------------------------------------------
package lpa_pkg;

  localparam int unsigned DEF_POOL_LIMIT = 65536;
  localparam int unsigned DEF_ADDR_WIDTH = 32;

  localparam int unsigned LEN_W     = 17;   // byte counts and offsets
  localparam int unsigned ADDR_W    = 32;   // address fields
  localparam int unsigned RND_W     = LEN_W + 1;  // rounded byte count
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned NUM_POOLS = 3;

  localparam logic [LEN_W-1:0] SIZE_RESET = 17'd65536;
  localparam logic [RND_W-1:0] GRAN_LOW   = 18'd7;

  // action codes
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_MARK    = 2'd2;
  localparam logic [1:0] ACT_RELEASE = 2'd3;

  // pool select code that names no pool
  localparam logic [1:0] POOL_BAD = 2'd3;

  // result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NO_SPACE = 2'd1;
  localparam logic [1:0] STS_IGNORED  = 2'd2;
  localparam logic [1:0] STS_BAD_POOL = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNCACHED_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_SIZE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNCACHED_SIZE = 3'd5;

  typedef struct packed {
    logic [1:0]        action;
    logic [1:0]        pool;
    logic [LEN_W-1:0]  req_bytes;
    logic [ADDR_W-1:0] free_address;
    logic [LEN_W-1:0]  mark_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [LEN_W-1:0]  top_offset;
    logic [LEN_W-1:0]  free_bytes;
    logic [LEN_W-1:0]  peak_bytes;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WRAP
  } ctrl_state_t;

  typedef struct packed {
    logic load_req;   // capture the incoming item
    logic exec;       // evaluate the request and update the pool
    logic load_out;   // move the result into the output register
  } lpa_cmd_t;

  typedef struct packed {
    logic out_free;   // output register empty or draining this cycle
    logic out_valid;  // output register holds an item
  } lpa_sts_t;

endpackage

/* hw/rtl/lpa_ctrl.sv */
// ----------------------------------------------------------------------------
// lpa_ctrl
// Sequencer: accept an item, execute it, then hand the result to the output.
// ----------------------------------------------------------------------------
module lpa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lpa_pkg::lpa_sts_t sts,
  output lpa_pkg::lpa_cmd_t cmd
);
  import lpa_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/lpa_datapath.sv */
// ----------------------------------------------------------------------------
// lpa_datapath
// Pool registers, configuration registers, request evaluation, output stage.
// ----------------------------------------------------------------------------
module lpa_datapath #(
  parameter int unsigned POOL_LIMIT = lpa_pkg::DEF_POOL_LIMIT,
  parameter int unsigned ADDR_WIDTH = lpa_pkg::DEF_ADDR_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lpa_pkg::in_item_t                in_data,
  input  logic                             cfg_valid,
  input  logic [lpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpa_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output lpa_pkg::out_item_t               out_data,
  input  lpa_pkg::lpa_cmd_t                cmd,
  output lpa_pkg::lpa_sts_t                sts
);
  import lpa_pkg::*;

  // top offsets never exceed the smaller of the limit and the size register range
  localparam int unsigned SIZE_MAX = (1 << LEN_W) - 1;
  localparam int unsigned CAP      = (POOL_LIMIT < SIZE_MAX) ? POOL_LIMIT : SIZE_MAX;
  localparam int unsigned TOP_W    = $clog2(CAP + 1);
  localparam int unsigned LIM_W    = $clog2(POOL_LIMIT + 1) > LEN_W ?
                                     $clog2(POOL_LIMIT + 1) : LEN_W;
  localparam logic [LIM_W-1:0] LIMIT_V = LIM_W'(POOL_LIMIT);

  // configuration
  logic [ADDR_W-1:0] base_r [NUM_POOLS];
  logic [LEN_W-1:0]  size_r [NUM_POOLS];

  // pool state
  logic [TOP_W-1:0]  top_r  [NUM_POOLS];
  logic [TOP_W-1:0]  peak_r [NUM_POOLS];

  // request and intermediate result
  in_item_t          req_r;
  logic [1:0]        res_status_r;
  logic [ADDR_WIDTH-1:0] res_addr_r;
  logic [TOP_W-1:0]  res_top_r;
  logic [TOP_W-1:0]  res_peak_r;
  logic [TOP_W-1:0]  eff_r;

  // output stage
  out_item_t         out_r;
  logic              out_valid_r, out_valid_nxt;

  // evaluation signals
  logic              bad;
  logic [1:0]        pi;
  logic [ADDR_W-1:0] base_sel;
  logic [LIM_W-1:0]  size_ext;
  logic [TOP_W-1:0]  eff;
  logic [TOP_W-1:0]  top;
  logic [TOP_W-1:0]  peak;
  logic [TOP_W-1:0]  free_cur;
  logic [RND_W-1:0]  rounded;
  logic              fits;
  logic [TOP_W-1:0]  alloc_top;
  logic [ADDR_WIDTH-1:0] top_addr;
  logic [ADDR_WIDTH-1:0] free_end;
  logic              free_ok;
  logic [TOP_W-1:0]  cap;
  logic [LEN_W-1:0]  mark_al;
  logic [TOP_W-1:0]  mark_top;
  logic [1:0]        status_nxt;
  logic [ADDR_WIDTH-1:0] addr_nxt;
  logic [TOP_W-1:0]  top_nxt;
  logic [TOP_W-1:0]  peak_nxt;
  logic [TOP_W-1:0]  free_out;

  always_comb begin
    bad      = (req_r.pool == POOL_BAD);
    pi       = bad ? 2'd0 : req_r.pool;
    base_sel = {base_r[pi][ADDR_W-1:3], 3'b000};
    size_ext = LIM_W'(size_r[pi]);
    eff      = (size_ext > LIMIT_V) ? TOP_W'(LIMIT_V) : TOP_W'(size_ext);
    top      = top_r[pi];
    peak     = peak_r[pi];
    free_cur = (eff > top) ? eff - top : '0;
    rounded  = (RND_W'(req_r.req_bytes) + GRAN_LOW) & ~GRAN_LOW;
    fits     = (rounded <= RND_W'(free_cur));
    alloc_top = top + TOP_W'(rounded);
    top_addr = ADDR_WIDTH'(base_sel) + ADDR_WIDTH'(top);
    free_end = ADDR_WIDTH'(req_r.free_address) + ADDR_WIDTH'(rounded);
    free_ok  = (rounded <= RND_W'(top)) && (free_end == top_addr);
    cap      = eff & ~TOP_W'(7);
    mark_al  = req_r.mark_offset & ~LEN_W'(7);
    mark_top = (mark_al > LEN_W'(cap)) ? cap : TOP_W'(mark_al);

    status_nxt = STS_OK;
    addr_nxt   = '0;
    top_nxt    = top;
    peak_nxt   = peak;
    case (req_r.action)
      ACT_ALLOC: begin
        if (fits) begin
          addr_nxt = top_addr;
          top_nxt  = alloc_top;
          if (alloc_top > peak) begin
            peak_nxt = alloc_top;
          end
        end else begin
          status_nxt = STS_NO_SPACE;
        end
      end
      ACT_FREE: begin
        if (free_ok) begin
          top_nxt = top - TOP_W'(rounded);
        end else begin
          status_nxt = STS_IGNORED;
        end
      end
      ACT_RELEASE: begin
        top_nxt = mark_top;
      end
      default: begin
        // mark: report only
      end
    endcase

    free_out = (eff_r > res_top_r) ? eff_r - res_top_r : '0;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        base_r[i] <= '0;
        size_r[i] <= SIZE_RESET;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NORMAL_BASE:   base_r[0] <= cfg_data;
        REG_FAST_BASE:     base_r[1] <= cfg_data;
        REG_UNCACHED_BASE: base_r[2] <= cfg_data;
        REG_NORMAL_SIZE:   size_r[0] <= cfg_data[LEN_W-1:0];
        REG_FAST_SIZE:     size_r[1] <= cfg_data[LEN_W-1:0];
        REG_UNCACHED_SIZE: size_r[2] <= cfg_data[LEN_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // pool state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        top_r[i]  <= '0;
        peak_r[i] <= '0;
      end
    end else if (cmd.exec && !bad) begin
      top_r[pi]  <= top_nxt;
      peak_r[pi] <= peak_nxt;
    end
  end

  // request capture and intermediate result
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      if (bad) begin
        res_status_r <= STS_BAD_POOL;
        res_addr_r   <= '0;
        res_top_r    <= '0;
        res_peak_r   <= '0;
        eff_r        <= '0;
      end else begin
        res_status_r <= status_nxt;
        res_addr_r   <= addr_nxt;
        res_top_r    <= top_nxt;
        res_peak_r   <= peak_nxt;
        eff_r        <= eff;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.status        <= res_status_r;
      out_r.block_address <= ADDR_W'(res_addr_r);
      out_r.top_offset    <= LEN_W'(res_top_r);
      out_r.free_bytes    <= LEN_W'(free_out);
      out_r.peak_bytes    <= LEN_W'(res_peak_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.out_valid = out_valid_r;

endmodule

/* hw/rtl/lifo_pool_allocator_top.sv */
// ----------------------------------------------------------------------------
// lifo_pool_allocator_top
// Three-pool stack allocator with alloc, top-only free, mark and release.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_data   (lpa_pkg::in_item_t)
//   out_     output     out_valid / out_ready  out_data  (lpa_pkg::out_item_t)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is accepted, executed against the selected pool's top register,
// then loaded into the output register; the controller accepts no new item
// until the current one has been loaded into the output register.
// A result waiting in the output register does not block the next accept;
// a stalled out_ready holds the following item in its last step.
// Reset (rst_n, synchronous) empties all pools and restores config defaults.
// Configuration writes are always taken (cfg_ready is held high).
// ----------------------------------------------------------------------------
module lifo_pool_allocator_top #(
  parameter int unsigned POOL_LIMIT = lpa_pkg::DEF_POOL_LIMIT,
  parameter int unsigned ADDR_WIDTH = lpa_pkg::DEF_ADDR_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lpa_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lpa_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpa_pkg::CFG_DAT_W-1:0] cfg_data
);
  import lpa_pkg::*;

  lpa_cmd_t cmd;
  lpa_sts_t sts;

  assign cfg_ready = 1'b1;

  lpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpa_datapath #(
    .POOL_LIMIT (POOL_LIMIT),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // one item in flight: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // a result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!sts.out_valid || out_ready))
    else $error("output register overwritten");

  // an accept leads to execution in the next cycle
  a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_req |=> cmd.exec)
    else $error("accepted item not executed");

  // a loaded result is presented on the output
  a_out_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule
